/* design/lbt_pkg.sv */
// ---------------------------------------------------------------------------
// lbt_pkg
// Shared types and constants for the multi-LED blink and timeout controller.
// ---------------------------------------------------------------------------
`default_nettype none

package lbt_pkg;

   localparam int LED_COUNT = 8;
   localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   localparam logic [15:0] SCAN_RESET = 16'd500;
   localparam logic [7:0]  FOREVER    = 8'hFF;
   localparam logic [15:0] NEVER      = 16'hFFFF;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_FLASH = 2'd2;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_CFG  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CFG,
      ST_ADD,
      ST_SUB,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // one LED's stored state
   typedef struct packed {
      logic [1:0]  mode;
      logic        level;
      logic [15:0] toggle_period;
      logic [15:0] toggle_countdown;
      logic [7:0]  toggles_left;
      logic [15:0] off_timeout;
      logic [15:0] off_countdown;
   } entry_type;

   // write port into the LED table
   typedef struct packed {
      logic                 en;
      logic [LED_IDX_W-1:0] idx;
      entry_type            entry;
   } wr_type;

endpackage

`default_nettype wire

/* design/lbt_alu.sv */
// ---------------------------------------------------------------------------
// lbt_alu
// Shared 16-bit add/subtract unit with borrow out.
// ---------------------------------------------------------------------------
`default_nettype none

module lbt_alu (
   input  wire logic [15:0] a,
   input  wire logic [15:0] b,
   input  wire logic        sub,
   output logic [15:0]      result,
   output logic             borrow
);

   logic [16:0] full;

   always_comb begin
      if (sub) begin
         full = {1'b0, a} - {1'b0, b};
      end else begin
         full = {1'b0, a} + {1'b0, b};
      end
      result = full[15:0];
      borrow = sub & full[16];
   end

endmodule

`default_nettype wire

/* design/lbt_led_bank.sv */
// ---------------------------------------------------------------------------
// lbt_led_bank
// Per-LED state table: one read port, one write port, cleared by reset.
// ---------------------------------------------------------------------------
`default_nettype none

module lbt_led_bank (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [lbt_pkg::LED_IDX_W-1:0] rd_idx,
   output lbt_pkg::entry_type                rd_entry,
   input  wire lbt_pkg::wr_type              wr
);

   lbt_pkg::entry_type bank_ff [lbt_pkg::LED_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lbt_pkg::LED_COUNT; i++) begin
            bank_ff[i] <= '0;
         end
      end else if (wr.en) begin
         bank_ff[wr.idx] <= wr.entry;
      end
   end

   assign rd_entry = bank_ff[rd_idx];

endmodule

`default_nettype wire

/* design/multi_led_blink_timeout_controller.sv */
// ---------------------------------------------------------------------------
// multi_led_blink_timeout_controller
// Drives LED_COUNT LEDs off, steady on or flashing; reports level changes.
// ---------------------------------------------------------------------------
// A configure transfer (tuser 1) rewrites one LED entry and always returns
// one result with that LED's new level, tlast set; ids at or above
// LED_COUNT are dropped with no result. A tick transfer (tuser 0) adds its
// elapsed time to the accumulator; once the accumulator reaches scan_period
// the period is subtracted and all LEDs are scanned in ascending order,
// one entry per cycle unless a held result register stalls the scan,
// returning one result per level change with tlast on the final one (a
// tick may return no result at all). The accumulator and countdown
// arithmetic runs through a single 16-bit add/subtract unit under a small
// sequencer, and req_tready is high only while the sequencer is idle. The
// sequencer may wait while the result register is held by rsp_tready low.
// One finished result may wait in the output register while the next
// request transfer is taken.
// scan_period is written through the csr channel, which is always ready;
// write it only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_led_blink_timeout_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] elapsed, [23:16] led_id, [25:24] mode, [41:26] timeout,
   // [57:42] flash_period, [65:58] flash_count, [71:66] zero
   input  wire logic [71:0] req_tdata,
   input  wire logic        req_tuser,    // [0] req_type
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [2:0] led_index, [3] led_level, [7:4] zero
   output logic             rsp_tlast,    // last
   // scan period register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);

   localparam int IW = lbt_pkg::LED_IDX_W;

   lbt_pkg::state_type state_ff, state_in;

   logic [15:0] scan_period_ff;
   logic [15:0] acc_ff, acc_in;
   logic [IW-1:0] scan_idx_ff, scan_idx_in;

   // latched request fields
   logic [15:0] elapsed_ff;
   logic [7:0]  led_id_ff;
   logic [1:0]  mode_ff;
   logic [15:0] timeout_ff;
   logic [15:0] fperiod_ff;
   logic [7:0]  fcount_ff;

   // change found but not yet known to be the last one
   logic          pend_valid_ff, pend_valid_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic          pend_lvl_ff, pend_lvl_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_idx_ff, rsp_idx_in;
   logic          rsp_lvl_ff, rsp_lvl_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_xfer;
   logic          out_free;

   logic [15:0]   alu_a, alu_b, alu_res;
   logic          alu_sub, alu_borrow;

   logic [IW-1:0] rd_idx;
   lbt_pkg::entry_type rd_entry, new_entry, cfg_entry;
   lbt_pkg::wr_type    wr;

   logic [15:0]   cd;
   logic          change, nlvl, stall;
   logic [7:0]    tl_dec;

   assign req_tready = (state_ff == lbt_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_lvl_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   lbt_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   assign rd_idx = scan_idx_ff;

   lbt_led_bank u_bank (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // entry built from a configure request
   always_comb begin
      cfg_entry      = '0;
      cfg_entry.mode = mode_ff;
      if (mode_ff == lbt_pkg::MODE_FLASH) begin
         cfg_entry.toggle_period    = fperiod_ff;
         cfg_entry.toggle_countdown = fperiod_ff;
         // 2n-1 modulo 256
         cfg_entry.toggles_left     = {fcount_ff[6:0], 1'b0} - 8'd1;
         cfg_entry.level            = 1'b1;
      end else begin
         cfg_entry.off_timeout   = timeout_ff;
         cfg_entry.off_countdown = timeout_ff;
         cfg_entry.level         = (mode_ff == lbt_pkg::MODE_ON);
      end
   end

   // scan step for the entry at scan_idx_ff; the ALU countdown result is cd
   always_comb begin
      cd        = alu_borrow ? 16'd0 : alu_res;
      new_entry = rd_entry;
      change    = 1'b0;
      nlvl      = 1'b0;
      tl_dec    = rd_entry.toggles_left - 8'd1;
      if (rd_entry.mode == lbt_pkg::MODE_FLASH) begin
         if (cd != 16'd0) begin
            new_entry.toggle_countdown = cd;
         end else begin
            nlvl                       = ~rd_entry.level;
            change                     = 1'b1;
            new_entry.toggle_countdown = rd_entry.toggle_period;
            if (rd_entry.toggles_left != lbt_pkg::FOREVER) begin
               new_entry.toggles_left = tl_dec;
               if (tl_dec == 8'd0) begin
                  new_entry.mode = lbt_pkg::MODE_OFF;
               end
            end
         end
      end else begin
         new_entry.off_countdown = cd;
         if (cd == 16'd0 && rd_entry.off_timeout != lbt_pkg::NEVER) begin
            change = rd_entry.level;
         end
      end
      if (change) begin
         new_entry.level = nlvl;
      end
      // a second change needs the output register to pass the first one on
      stall = change & pend_valid_ff & ~out_free;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_lvl_in   = pend_lvl_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      rsp_last_in   = rsp_last_ff;
      alu_a         = acc_ff;
      alu_b         = scan_period_ff;
      alu_sub       = 1'b1;
      wr            = '0;

      case (state_ff)
         lbt_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == lbt_pkg::REQ_CFG) begin
                  // unknown LED ids are dropped here
                  if ({1'b0, req_tdata[23:16]} < 9'(lbt_pkg::LED_COUNT)) begin
                     state_in = lbt_pkg::ST_CFG;
                  end
               end else begin
                  state_in = lbt_pkg::ST_ADD;
               end
            end
         end
         lbt_pkg::ST_CFG: begin
            if (out_free) begin
               wr.en        = 1'b1;
               wr.idx       = IW'(led_id_ff);
               wr.entry     = cfg_entry;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 3'(led_id_ff);
               rsp_lvl_in   = cfg_entry.level;
               rsp_last_in  = 1'b1;
               state_in     = lbt_pkg::ST_IDLE;
            end
         end
         lbt_pkg::ST_ADD: begin
            alu_b    = elapsed_ff;
            alu_sub  = 1'b0;
            acc_in   = alu_res;
            state_in = lbt_pkg::ST_SUB;
         end
         lbt_pkg::ST_SUB: begin
            if (alu_borrow) begin
               state_in = lbt_pkg::ST_IDLE;
            end else begin
               acc_in      = alu_res;
               scan_idx_in = '0;
               state_in    = lbt_pkg::ST_SCAN;
            end
         end
         lbt_pkg::ST_SCAN: begin
            alu_a = (rd_entry.mode == lbt_pkg::MODE_FLASH) ?
                    rd_entry.toggle_countdown : rd_entry.off_countdown;
            if (!stall) begin
               wr.en    = 1'b1;
               wr.idx   = scan_idx_ff;
               wr.entry = new_entry;
               if (change) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = 3'(pend_idx_ff);
                     rsp_lvl_in   = pend_lvl_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = scan_idx_ff;
                  pend_lvl_in   = nlvl;
               end
               if (scan_idx_ff == IW'(lbt_pkg::LED_COUNT - 1)) begin
                  state_in = lbt_pkg::ST_FLUSH;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         lbt_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = lbt_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = 3'(pend_idx_ff);
               rsp_lvl_in    = pend_lvl_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = lbt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lbt_pkg::ST_IDLE;
         scan_period_ff <= lbt_pkg::SCAN_RESET;
         acc_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            scan_period_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_lvl_ff <= pend_lvl_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_last_ff <= rsp_last_in;
      if (req_xfer) begin
         elapsed_ff <= req_tdata[15:0];
         led_id_ff  <= req_tdata[23:16];
         mode_ff    <= req_tdata[25:24];
         timeout_ff <= req_tdata[41:26];
         fperiod_ff <= req_tdata[57:42];
         fcount_ff  <= req_tdata[65:58];
      end
   end

`ifndef SYNTHESIS
   // a pending change never survives past the end of a scan
   a_pend_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbt_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   // the LED table is written only while configuring or scanning
   a_wr_states: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == lbt_pkg::ST_CFG || state_ff == lbt_pkg::ST_SCAN))
      else $error("LED table written outside configure or scan");

   // a tick transfer always goes through the accumulator add
   a_tick_add: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == lbt_pkg::REQ_TICK) |=> (state_ff == lbt_pkg::ST_ADD))
      else $error("tick transfer did not start accumulation");
`endif

endmodule

`default_nettype wire

/* sim/tb_multi_led_blink_timeout_controller.sv */
// ---------------------------------------------------------------------------
// tb_multi_led_blink_timeout_controller
// Self-checking bench: drives configure and tick transfers, predicts each
// configure result and level change from its LED table; checks each in order.
// ---------------------------------------------------------------------------
module tb_multi_led_blink_timeout_controller;
   import lbt_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;   // stored, behaves as off
   localparam int         CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [LED_IDX_W-1:0] led_index;
      logic                 led_level;
      logic                 last;
   } led_change_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata  = '0;

   // predictor state
   entry_type      led_table [LED_COUNT];
   logic [15:0]    elapsed_sum = '0;
   logic [15:0]    scan_ms     = SCAN_RESET;
   led_change_type led_changes_due [$];

   int             error_count = 0;
   bit             calm = 1'b0;        // no idling on either side
   int             rsp_hold_left = 0;  // long receiver hold-off, counted below
   int             rsp_stall_left = 0;
   led_change_type want;

   multi_led_blink_timeout_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // ---- prediction ------------------------------------------------------
   task automatic apply_led_request(input logic kind, input logic [71:0] data);
      entry_type             e;
      logic [7:0]            id;
      logic [LED_COUNT-1:0]  changed;
      led_change_type        c;
      int                    i;
      int                    last_i;
      id      = data[23:16];
      changed = '0;
      last_i  = 0;
      if (kind == REQ_CFG) begin
         if (id < LED_COUNT) begin
            e      = '0;
            e.mode = data[25:24];
            if (e.mode == MODE_FLASH) begin
               e.toggle_period    = data[57:42];
               e.toggle_countdown = data[57:42];
               e.toggles_left     = (data[65:58] << 1) - 8'd1;
               e.level            = 1'b1;
            end else begin
               e.off_timeout   = data[41:26];
               e.off_countdown = data[41:26];
               e.level         = (e.mode == MODE_ON);
            end
            led_table[id] = e;
            c.led_index   = id[LED_IDX_W-1:0];
            c.led_level   = e.level;
            c.last        = 1'b1;
            led_changes_due.push_back(c);
         end
      end else begin
         elapsed_sum = elapsed_sum + data[15:0];
         if (elapsed_sum >= scan_ms) begin
            elapsed_sum = elapsed_sum - scan_ms;
            for (i = 0; i < LED_COUNT; i++) begin
               e = led_table[i];
               if (e.mode == MODE_FLASH) begin
                  e.toggle_countdown = (e.toggle_countdown >= scan_ms) ?
                                       e.toggle_countdown - scan_ms : 16'd0;
                  if (e.toggle_countdown == 16'd0) begin
                     changed[i]         = 1'b1;
                     e.level            = ~e.level;
                     e.toggle_countdown = e.toggle_period;
                     if (e.toggles_left != FOREVER) begin
                        e.toggles_left = e.toggles_left - 8'd1;
                        if (e.toggles_left == 8'd0)
                           e.mode = MODE_OFF;
                     end
                  end
               end else begin
                  e.off_countdown = (e.off_countdown >= scan_ms) ?
                                    e.off_countdown - scan_ms : 16'd0;
                  // forced off once the timeout runs out, unless it never does
                  if (e.off_countdown == 16'd0 && e.off_timeout != NEVER && e.level) begin
                     changed[i] = 1'b1;
                     e.level    = 1'b0;
                  end
               end
               led_table[i] = e;
               if (changed[i])
                  last_i = i;
            end
            for (i = 0; i < LED_COUNT; i++) begin
               if (changed[i]) begin
                  c.led_index = i[LED_IDX_W-1:0];
                  c.led_level = led_table[i].level;
                  c.last      = (i == last_i);
                  led_changes_due.push_back(c);
               end
            end
         end
      end
   endtask

   // ---- response checking ------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (led_changes_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer, expected none, got index %0d level %0d last %0d",
                     $time, rsp_tdata[2:0], rsp_tdata[3], rsp_tlast);
         end else begin
            want = led_changes_due.pop_front();
            if (rsp_tdata[2:0] !== want.led_index) begin
               error_count++;
               $display("%0t: led_index expected %0d, got %0d",
                        $time, want.led_index, rsp_tdata[2:0]);
            end
            if (rsp_tdata[3] !== want.led_level) begin
               error_count++;
               $display("%0t: led_level expected %0d, got %0d",
                        $time, want.led_level, rsp_tdata[3]);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: last expected %0d, got %0d", $time, want.last, rsp_tlast);
            end
         end
      end
   end

   // receiver: random stall bursts, or a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
               rsp_stall_left = $urandom_range(1, 7);
         end
      end
   end

   // ---- stimulus helpers --------------------------------------------------
   // valid stays high after a transfer; the next call replaces the data or
   // drops valid for a gap
   task automatic send_item(input logic kind, input logic [71:0] data);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      apply_led_request(kind, data);
   endtask

   task automatic send_tick(input logic [15:0] elapsed);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      send_item(REQ_TICK, {6'b0, noise[49:0], elapsed});
   endtask

   task automatic send_config(input logic [7:0] id, input logic [1:0] mode,
                              input logic [15:0] tmo, input logic [15:0] per,
                              input logic [7:0] flashes);
      logic [31:0] noise;
      noise = $urandom;
      send_item(REQ_CFG, {6'b0, flashes, per, tmo, mode, id, noise[15:0]});
   endtask

   // drop valid and wait out every expected change, then settle
   task automatic wait_changes_done(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (led_changes_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_scan_period(input logic [15:0] period);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= period;
      do @(posedge clock); while (!csr_ready);
      scan_ms = period;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // timeouts and flash periods: zero, NEVER, random, or zero to three scan periods
   function automatic logic [15:0] pick_span();
      int v;
      case ($urandom_range(0, 7))
         0:       v = 0;
         1:       v = int'(NEVER);
         2:       v = $urandom_range(0, 65535);
         default: v = scan_ms * $urandom_range(0, 3);
      endcase
      if (v > 65535)
         v = 65535;
      return v[15:0];
   endfunction

   function automatic logic [7:0] pick_flashes();
      int v;
      case ($urandom_range(0, 7))
         0:       v = 0;
         1:       v = 128;
         2:       v = 255;
         3:       v = $urandom_range(0, 255);
         default: v = $urandom_range(1, 3);
      endcase
      return v[7:0];
   endfunction

   function automatic logic [1:0] pick_mode();
      int v;
      v = $urandom_range(0, 2);
      return ($urandom_range(0, 7) == 0) ? MODE_UNUSED : v[1:0];
   endfunction

   // ---- tests -------------------------------------------------------------
   task automatic test_directed();
      send_config(8'd0, MODE_ON, 16'd0, 16'd0, 8'd0);        // on, zero timeout
      send_config(8'd1, MODE_ON, NEVER, 16'd0, 8'd0);        // on for good
      send_config(8'd2, MODE_FLASH, 16'd0, 16'd0, 8'd1);     // zero period, one flash
      send_config(8'd3, MODE_FLASH, 16'd0, 16'd1000, 8'd0);  // forever
      send_config(8'd4, MODE_FLASH, 16'd0, 16'hFFFF, 8'd128); // forever, longest period
      send_config(8'd5, MODE_UNUSED, 16'd1000, 16'd0, 8'd0);
      send_config(8'd6, MODE_OFF, 16'd500, 16'd0, 8'd0);
      send_config(8'd7, MODE_FLASH, 16'd0, 16'd500, 8'd255);
      send_config(8'd8, MODE_ON, 16'd100, 16'd0, 8'd0);      // unknown id, dropped
      send_config(8'd255, MODE_FLASH, NEVER, 16'hFFFF, 8'hFF);
      send_tick(16'd0);
      send_tick(16'd499);
      send_tick(16'd1);                                      // reaches the period
      send_tick(16'hFFFF);                                   // accumulator reaches 16'hFFFF; the next tick wraps it
      send_tick(16'hFFFF);
      send_tick(16'd500);
      send_config(8'd2, MODE_FLASH, 16'd0, 16'd0, 8'd2);
      send_tick(16'd1000);
      send_tick(16'd500);
      send_tick(16'd500);
      wait_changes_done(0);
   endtask

   task automatic test_random_phase(input logic [15:0] period, input int items);
      int k;
      int span;
      int e_ms;
      wait_changes_done(20);
      write_scan_period(period);
      span = (scan_ms == 16'd0) ? 200 : scan_ms;
      for (k = 0; k < items; k++) begin
         if (!calm && $urandom_range(0, 39) == 0)
            wait_changes_done(0);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: begin
               case ($urandom_range(0, 9))
                  0:       e_ms = 0;
                  1:       e_ms = $urandom_range(0, 65535);
                  default: e_ms = $urandom_range(0, span + span / 2);
               endcase
               if (e_ms > 65535)
                  e_ms = 65535;
               send_tick(e_ms[15:0]);
            end
            19:
               send_config(8'($urandom_range(LED_COUNT, 255)), pick_mode(),
                           pick_span(), pick_span(), pick_flashes());
            default:
               send_config(8'($urandom_range(0, LED_COUNT - 1)), pick_mode(),
                           pick_span(), pick_span(), pick_flashes());
         endcase
      end
   endtask

   // receiver holds off while configure transfers keep coming, so the
   // output register fills and the block stalls its input
   task automatic test_backpressure();
      int k;
      wait_changes_done(0);
      rsp_hold_left = 150;
      for (k = 0; k < 20; k++)
         send_config(8'($urandom_range(0, LED_COUNT - 1)), pick_mode(),
                     pick_span(), pick_span(), pick_flashes());
      wait_changes_done(0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(16'd500, 70);
      test_random_phase(16'd1, 40);
      test_random_phase(16'hFFFF, 40);
      test_random_phase(16'd0, 30);
      test_random_phase(16'($urandom_range(2, 2000)), 40);
      test_backpressure();
      calm = 1'b1;
      test_random_phase(16'd250, 60);
      wait_changes_done(20);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
